// File: hdl/svph_pkg.sv
// Shared types, constants and register indexes of the servo pulse generator.
package svph_pkg;

  // Shortest frame length in microseconds; longer pulses stretch the frame.
  localparam logic [14:0] FRAME_MIN_US = 15'd20000;

  // Microseconds per millisecond, for the hold check.
  localparam logic [23:0] US_PER_MS = 24'd1000;

  // Saturation value of the hold counter.
  localparam logic [23:0] HOLD_SAT = 24'hFFFFFF;

  // Divider sizes: numerator 2*|d*dx| + span, denominator 2*span.
  localparam int NUM_W     = 30;
  localparam int DEN_W     = 14;
  localparam int QUO_W     = 16;
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port sizes.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 15;

  // Register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PULSE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PULSE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_ANGLE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ANGLE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SLEW      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_MS   = 3'd7;

  // Request kinds on in_tuser.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CMD  = 1'b1;

  // Configuration register file contents.
  typedef struct packed {
    logic        [14:0] min_pulse;
    logic        [14:0] max_pulse;
    logic signed [12:0] min_angle;
    logic signed [12:0] max_angle;
    logic signed [12:0] center;
    logic        [14:0] slew;
    logic        [14:0] deadband;
    logic        [13:0] hold_ms;
  } cfg_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic        is_cmd;
    logic        span_ok;
    logic [12:0] d;
  } qent_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: hdl/svph_front.sv
// Input stage: accepts transactions and classifies them, clamping command angles.
module svph_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  svph_pkg::cfg_t        cfg,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [12:0] angle_offset
  input  logic                  in_tuser,   // [0] req_type
  output logic                  push,
  output svph_pkg::qent_t       push_ent,
  input  logic                  q_ready
);
  import svph_pkg::*;

  logic        fv_r, fv_nxt;
  qent_t       ent_r;
  qent_t       ent_nxt;
  logic        in_acc;

  logic signed [13:0] ang;
  logic signed [13:0] lo;
  logic signed [13:0] hi;
  logic signed [13:0] clamped;
  logic signed [14:0] d_full;
  logic signed [13:0] span;

  assign in_tready = !fv_r || q_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign push      = fv_r && q_ready;
  assign push_ent  = ent_r;

  // Angle clamp: low limit first, then high limit.
  always_comb begin
    ang  = 14'(cfg.center) - 14'($signed(in_tdata[12:0]));
    lo   = 14'(cfg.min_angle);
    hi   = 14'(cfg.max_angle);
    span = hi - lo;
    if (ang < lo) begin
      clamped = lo;
    end else if (ang > hi) begin
      clamped = hi;
    end else begin
      clamped = ang;
    end
    d_full = 15'(clamped) - 15'(lo);
    ent_nxt.is_cmd  = (in_tuser == REQ_CMD);
    ent_nxt.span_ok = (span > 14'sd0);
    ent_nxt.d       = d_full[12:0];
  end

  // Valid flag of the stage register.
  always_comb begin
    fv_nxt = fv_r;
    if (in_acc) begin
      fv_nxt = 1'b1;
    end else if (push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// File: hdl/svph_queue.sv
// Two-entry queue between the front and the back.
module svph_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  svph_pkg::qent_t  push_ent,
  output logic             q_ready,
  input  logic             pop,
  output logic             q_valid,
  output svph_pkg::qent_t  head
);
  import svph_pkg::*;

  qent_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign q_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign head    = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

// File: hdl/svph_div.sv
// Restoring divider that produces two quotient bits per cycle.
module svph_div (
  input  logic                clk,
  input  logic                rst_n,
  input  svph_pkg::div_req_t  req,
  output svph_pkg::div_rsp_t  rsp
);
  import svph_pkg::*;

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0]     num_r;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W-1:0]     rem_r;
  logic [QUO_W-1:0]     quo_r;

  logic [DEN_W:0]       r_a, r_b;
  logic [DEN_W:0]       s_a, s_b;
  logic                 ge_a, ge_b;
  logic [DEN_W-1:0]     rem_a, rem_b;

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

  // Two dependent compare-and-subtract steps.
  always_comb begin
    r_a   = {rem_r, num_r[NUM_W-1]};
    ge_a  = (r_a >= {1'b0, den_r});
    s_a   = ge_a ? (r_a - {1'b0, den_r}) : r_a;
    rem_a = s_a[DEN_W-1:0];
    r_b   = {rem_a, num_r[NUM_W-2]};
    ge_b  = (r_b >= {1'b0, den_r});
    s_b   = ge_b ? (r_b - {1'b0, den_r}) : r_b;
    rem_b = s_b[DEN_W-1:0];
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      num_r <= {num_r[NUM_W-3:0], 2'b00};
      rem_r <= rem_b;
      quo_r <= {quo_r[QUO_W-3:0], ge_a, ge_b};
    end
  end

endmodule

// File: hdl/svph_back.sv
// Execution stage: pulse state, frame timing, angle mapping and result register.
module svph_back (
  input  logic                clk,
  input  logic                rst_n,
  input  svph_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  svph_pkg::qent_t     head,
  output logic                pop,
  output svph_pkg::div_req_t  div_req,
  input  svph_pkg::div_rsp_t  div_rsp,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata    // [0] pwm_level, [1] output_active,
                                           // [16:2] current_pulse_us,
                                           // [31:17] target_pulse_us
);
  import svph_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]  st_r, st_nxt;

  // Block state.
  logic        active_r, active_nxt;
  logic [14:0] cur_r, cur_nxt;
  logic [14:0] tgt_r, tgt_nxt;
  logic [14:0] ftgt_r, ftgt_nxt;
  logic [14:0] phase_r, phase_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic [23:0] since_r, since_nxt;

  // Command working registers.
  logic [12:0]        d_r;
  logic               span_ok_r;
  logic signed [29:0] prod_r;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  logic        out_free;
  logic        do_tick;
  logic        do_cmd_pop;
  logic        do_fin;
  logic        level;

  // Tick datapath.
  logic signed [15:0] diff;
  logic signed [15:0] slew_s;
  logic [14:0]        frame_len;
  logic [14:0]        phase_inc;
  logic signed [15:0] err_s;
  logic [14:0]        err_abs;
  logic [23:0]        hold_us;

  // Command datapath.
  logic signed [15:0] dx;
  logic [28:0]        mag;
  logic signed [13:0] span_full;
  logic [12:0]        span;
  logic [QUO_W-1:0]   q;
  logic signed [17:0] pulse;
  logic [14:0]        pulse_cl;

  assign out_free   = !out_valid_r || out_tready;
  assign do_tick    = (st_r == ST_IDLE) && q_valid && !head.is_cmd && out_free;
  assign do_cmd_pop = (st_r == ST_IDLE) && q_valid && head.is_cmd;
  assign do_fin     = (st_r == ST_FIN) && out_free;
  assign pop        = do_tick || do_cmd_pop;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Mapping arithmetic.
  always_comb begin
    dx        = 16'($signed({1'b0, cfg.max_pulse})) - 16'($signed({1'b0, cfg.min_pulse}));
    span_full = 14'(cfg.max_angle) - 14'(cfg.min_angle);
    span      = span_full[12:0];
    mag       = prod_r[29] ? 29'(-prod_r) : prod_r[28:0];
    div_req.start = (st_r == ST_PREP);
    div_req.num   = NUM_W'({mag, 1'b0}) + NUM_W'(span);
    div_req.den   = DEN_W'({span, 1'b0});
    q     = span_ok_r ? div_rsp.quot : '0;
    pulse = prod_r[29] ? (18'($signed({1'b0, cfg.min_pulse})) - 18'($signed({1'b0, q})))
                       : (18'($signed({1'b0, cfg.min_pulse})) + 18'($signed({1'b0, q})));
    if (pulse < 18'($signed({1'b0, cfg.min_pulse}))) begin
      pulse_cl = cfg.min_pulse;
    end else if (pulse > 18'($signed({1'b0, cfg.max_pulse}))) begin
      pulse_cl = cfg.max_pulse;
    end else begin
      pulse_cl = pulse[14:0];
    end
  end

  // State update for ticks and finished commands.
  always_comb begin
    active_nxt   = active_r;
    cur_nxt      = cur_r;
    tgt_nxt      = tgt_r;
    ftgt_nxt     = ftgt_r;
    phase_nxt    = phase_r;
    in_frame_nxt = in_frame_r;
    since_nxt    = since_r;
    level        = in_frame_r && (phase_r < cur_r);
    slew_s       = 16'($signed({1'b0, cfg.slew}));
    diff         = 16'($signed({1'b0, tgt_r})) - 16'($signed({1'b0, cur_r}));
    hold_us      = 24'(cfg.hold_ms) * US_PER_MS;
    frame_len    = FRAME_MIN_US;
    phase_inc    = '0;
    err_s        = '0;
    err_abs      = '0;
    if (do_tick) begin
      if (since_r != HOLD_SAT) begin
        since_nxt = since_r + 24'd1;
      end
      // A new frame first slews toward the target.
      if (active_r && !in_frame_r) begin
        if (diff > slew_s) begin
          diff = slew_s;
        end
        if (diff < -slew_s) begin
          diff = -slew_s;
        end
        cur_nxt      = cur_r + diff[14:0];
        ftgt_nxt     = tgt_r;
        phase_nxt    = '0;
        in_frame_nxt = 1'b1;
      end
      level = in_frame_nxt && (phase_nxt < cur_nxt);
      if (in_frame_nxt) begin
        frame_len = (cur_nxt > FRAME_MIN_US) ? cur_nxt : FRAME_MIN_US;
        phase_inc = phase_nxt + 15'd1;
        phase_nxt = phase_inc;
        // End of frame: release when on target and the hold has passed.
        if (phase_inc >= frame_len) begin
          err_s        = 16'($signed({1'b0, cur_nxt})) - 16'($signed({1'b0, ftgt_nxt}));
          err_abs      = err_s[15] ? 15'(-err_s) : err_s[14:0];
          in_frame_nxt = 1'b0;
          phase_nxt    = '0;
          if ((err_abs <= cfg.deadband) && (since_nxt >= hold_us)) begin
            active_nxt = 1'b0;
          end
        end
      end
    end else if (do_fin) begin
      tgt_nxt    = pulse_cl;
      since_nxt  = '0;
      active_nxt = 1'b1;
    end
  end

  // Sequencer for commands.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (do_cmd_pop) begin
          st_nxt = head.span_ok ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL:  st_nxt = ST_PREP;
      ST_PREP: st_nxt = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Result register load.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (do_tick || do_fin) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {tgt_nxt, cur_nxt, active_nxt, level};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      cur_r       <= 15'd1500;
      tgt_r       <= 15'd1500;
      ftgt_r      <= 15'd1500;
      phase_r     <= '0;
      in_frame_r  <= 1'b0;
      since_r     <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      cur_r       <= cur_nxt;
      tgt_r       <= tgt_nxt;
      ftgt_r      <= ftgt_nxt;
      phase_r     <= phase_nxt;
      in_frame_r  <= in_frame_nxt;
      since_r     <= since_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (do_cmd_pop) begin
      d_r       <= head.d;
      span_ok_r <= head.span_ok;
      prod_r    <= '0;
    end else if (st_r == ST_MUL) begin
      prod_r <= $signed(30'($signed({1'b0, d_r}))) * $signed(30'(dx));
    end
  end

endmodule

// File: hdl/servo_pwm_slew_hold_unit.sv
// Top level of the servo pulse generator: register file and stage wiring.
//
// Input transactions carry either a one microsecond tick (in_tuser = 0) or an
// angle command (in_tuser = 1, offset in in_tdata). Every input transaction
// gives exactly one result transaction on the out_ channel: line level, output
// active flag, current and target pulse width.
// The front stage registers and classifies each transaction and hands it to a
// two-entry queue; the back stage executes it and loads the result register.
// A tick passes the front register, the queue and the result register; ticks
// flow at one per cycle while no command runs and the receiver takes each result.
// An angle command runs the product, divider set-up, radix-4 divider and finish
// states in turn (only finish when the angle span is empty) and holds the back stage until done.
// The input side keeps accepting while a result waits, until the queue and the
// front register are full. When the receiver stalls, the result register holds
// its value and the stages behind it fill up and stop in turn.
// Registers are written through cfg_we, cfg_addr and cfg_wdata; the user does so only while
// idle, which the block does not enforce. Synchronous reset loads the register defaults,
// empties the queue and puts the pulse state at 1500 us with the output inactive.
module servo_pwm_slew_hold_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [svph_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [svph_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,    // [12:0] angle_offset
  input  logic                             in_tuser,    // [0] req_type
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata    // [0] pwm_level,
                                                        // [1] output_active,
                                                        // [16:2] current_pulse_us,
                                                        // [31:17] target_pulse_us
);
  import svph_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      push;
  qent_t     push_ent;
  logic      q_ready;
  logic      pop;
  logic      q_valid;
  qent_t     head;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  // Register file writes; values are masked to each register's width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_MIN_PULSE: cfg_nxt.min_pulse = cfg_wdata;
        REG_MAX_PULSE: cfg_nxt.max_pulse = cfg_wdata;
        REG_MIN_ANGLE: cfg_nxt.min_angle = cfg_wdata[12:0];
        REG_MAX_ANGLE: cfg_nxt.max_angle = cfg_wdata[12:0];
        REG_CENTER:    cfg_nxt.center    = cfg_wdata[12:0];
        REG_SLEW:      cfg_nxt.slew      = cfg_wdata;
        REG_DEADBAND:  cfg_nxt.deadband  = cfg_wdata;
        REG_HOLD_MS:   cfg_nxt.hold_ms   = cfg_wdata[13:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pulse <= 15'd500;
      cfg_r.max_pulse <= 15'd2500;
      cfg_r.min_angle <= 13'sd0;
      cfg_r.max_angle <= 13'sd1800;
      cfg_r.center    <= 13'sd1000;
      cfg_r.slew      <= 15'd15;
      cfg_r.deadband  <= 15'd6;
      cfg_r.hold_ms   <= 14'd250;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  svph_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_ent  (push_ent),
    .q_ready   (q_ready)
  );

  svph_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  svph_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  svph_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: test/tb_servo_pwm_slew_hold_unit.sv
// Self-checking testbench for the servo pulse generator: directed table, then randomized phases.
module tb_servo_pwm_slew_hold_unit;
  import svph_pkg::*;

  // One result transaction, laid out as on out_tdata.
  typedef struct packed {
    logic [14:0] target_pulse_us;
    logic [14:0] current_pulse_us;
    logic        output_active;
    logic        pwm_level;
  } servo_out_t;

  // Directed table rows are either input items or register writes.
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic                     req;
    logic [CFG_ADDR_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]    value;
    logic                     typed;
    servo_out_t               want;
  } dir_row_t;

  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 150;
  localparam int DIR_ROWS    = 24;

  // Typed expectations hold only for reset defaults and clamped extremes.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_ITEM, REQ_TICK, REG_MIN_PULSE, 15'h0000, 1'b1, '{15'd1500, 15'd1500, 1'b0, 1'b0}},
    '{ROW_ITEM, REQ_TICK, REG_MIN_PULSE, 15'h1ABC, 1'b1, '{15'd1500, 15'd1500, 1'b0, 1'b0}},
    '{ROW_ITEM, REQ_CMD,  REG_MIN_PULSE, 15'h1000, 1'b1, '{15'd2500, 15'd1500, 1'b1, 1'b0}},
    '{ROW_ITEM, REQ_TICK, REG_MIN_PULSE, 15'h0FFF, 1'b1, '{15'd2500, 15'd1515, 1'b1, 1'b1}},
    '{ROW_ITEM, REQ_CMD,  REG_MIN_PULSE, 15'h0FFF, 1'b1, '{15'd500,  15'd1515, 1'b1, 1'b1}},
    '{ROW_ITEM, REQ_CMD,  REG_MIN_PULSE, 15'h0000, 1'b0, '0},
    '{ROW_ITEM, REQ_TICK, REG_MIN_PULSE, 15'h0000, 1'b0, '0},
    '{ROW_ITEM, REQ_CMD,  REG_MIN_PULSE, 15'd1000, 1'b1, '{15'd500,  15'd1515, 1'b1, 1'b1}},
    '{ROW_ITEM, REQ_CMD,  REG_MIN_PULSE, 15'h1CE0, 1'b1, '{15'd2500, 15'd1515, 1'b1, 1'b1}},
    '{ROW_REG,  REQ_TICK, REG_MAX_ANGLE, 15'd4,    1'b0, '0},
    '{ROW_REG,  REQ_TICK, REG_MIN_PULSE, 15'd0,    1'b0, '0},
    '{ROW_REG,  REQ_TICK, REG_MAX_PULSE, 15'd2,    1'b0, '0},
    '{ROW_REG,  REQ_TICK, REG_CENTER,    15'd0,    1'b0, '0},
    '{ROW_ITEM, REQ_CMD,  REG_MIN_PULSE, 15'h1FFF, 1'b0, '0},
    '{ROW_ITEM, REQ_CMD,  REG_MIN_PULSE, 15'h1FFD, 1'b0, '0},
    '{ROW_REG,  REQ_TICK, REG_MIN_PULSE, 15'd10,   1'b0, '0},
    '{ROW_ITEM, REQ_CMD,  REG_MIN_PULSE, 15'h1FFD, 1'b0, '0},
    '{ROW_REG,  REQ_TICK, REG_MAX_ANGLE, 15'h7000, 1'b0, '0},
    '{ROW_ITEM, REQ_CMD,  REG_MIN_PULSE, 15'h0000, 1'b0, '0},
    '{ROW_REG,  REQ_TICK, REG_MIN_PULSE, 15'd0,    1'b0, '0},
    '{ROW_REG,  REQ_TICK, REG_MAX_PULSE, 15'd0,    1'b0, '0},
    '{ROW_ITEM, REQ_CMD,  REG_MIN_PULSE, 15'd5,    1'b0, '0},
    '{ROW_ITEM, REQ_TICK, REG_MIN_PULSE, 15'h0000, 1'b0, '0},
    '{ROW_ITEM, REQ_TICK, REG_MIN_PULSE, 15'h0000, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;   // [12:0] angle_offset
  logic                  in_tuser = 1'b0; // [0] req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;       // [0] pwm_level, [1] output_active,
                                          // [16:2] current_pulse_us, [31:17] target_pulse_us

  servo_pwm_slew_hold_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Shadow copy of the pulse generator state and its registers.
  cfg_t        pw_cfg = '{15'd500, 15'd2500, 13'sd0, 13'sd1800, 13'sd1000,
                          15'd15, 15'd6, 14'd250};
  logic        pw_active = 1'b0;
  logic [14:0] pw_current = 15'd1500;
  logic [14:0] pw_target = 15'd1500;
  logic [14:0] pw_frame_target = 15'd1500;
  int          pw_phase = 0;
  logic        pw_in_frame = 1'b0;
  logic [23:0] pw_since_cmd = '0;

  servo_out_t  pending_outputs[$];
  servo_out_t  seen_out;
  servo_out_t  want_out;
  logic [14:0] phase_vals [8];

  int idle_pct = 34;
  int stall_pct = 34;
  int bad_results = 0;
  int results_seen = 0;
  int n_items = 0;
  int n_cmds = 0;
  int n_settings = 0;
  int frames_done = 0;
  int releases = 0;

  // Maps a commanded offset to a clamped, rounded pulse width.
  function automatic logic [14:0] angle_to_pulse(input logic [12:0] offs);
    longint off, amin, amax, ang, span, pmin, pmax, num, mag, q, pulse;
    off   = $signed(offs);
    amin  = $signed(pw_cfg.min_angle);
    amax  = $signed(pw_cfg.max_angle);
    pmin  = pw_cfg.min_pulse;
    pmax  = pw_cfg.max_pulse;
    ang   = longint'($signed(pw_cfg.center)) - off;
    span  = amax - amin;
    pulse = pmin;
    if (ang < amin) ang = amin;
    else if (ang > amax) ang = amax;
    if (span > 0) begin
      num = (ang - amin) * (pmax - pmin);
      mag = (num < 0) ? -num : num;
      q = (2 * mag + span) / (2 * span);
      pulse = pulse + ((num < 0) ? -q : q);
    end
    if (pulse < pmin) pulse = pmin;
    else if (pulse > pmax) pulse = pmax;
    return pulse[14:0];
  endfunction

  // Advances the shadow state by one item and returns the line status it causes.
  function automatic servo_out_t next_servo_output(input logic kind, input logic [12:0] offs);
    servo_out_t r;
    int         diff;
    int         slew;
    int         flen;
    int         err;
    logic       lvl;
    if (kind == REQ_CMD) begin
      pw_target = angle_to_pulse(offs);
      pw_since_cmd = '0;
      pw_active = 1'b1;
      lvl = pw_in_frame && (pw_phase < int'(pw_current));
    end else begin
      if (pw_since_cmd != HOLD_SAT) pw_since_cmd = pw_since_cmd + 24'd1;
      // A new frame first slews the width toward the target.
      if (pw_active && !pw_in_frame) begin
        slew = int'(pw_cfg.slew);
        diff = int'(pw_target) - int'(pw_current);
        if (diff > slew) diff = slew;
        if (diff < -slew) diff = -slew;
        pw_current = 15'(int'(pw_current) + diff);
        pw_frame_target = pw_target;
        pw_phase = 0;
        pw_in_frame = 1'b1;
      end
      lvl = pw_in_frame && (pw_phase < int'(pw_current));
      // Frame end: release when on target and the hold has run out.
      if (pw_in_frame) begin
        flen = (int'(pw_current) > int'(FRAME_MIN_US)) ? int'(pw_current) : int'(FRAME_MIN_US);
        pw_phase++;
        if (pw_phase >= flen) begin
          err = int'(pw_current) - int'(pw_frame_target);
          if (err < 0) err = -err;
          pw_in_frame = 1'b0;
          pw_phase = 0;
          frames_done++;
          if (err <= int'(pw_cfg.deadband) &&
              int'(pw_since_cmd) >= int'(pw_cfg.hold_ms) * int'(US_PER_MS)) begin
            pw_active = 1'b0;
            releases++;
          end
        end
      end
    end
    r.pwm_level = lvl;
    r.output_active = pw_active;
    r.current_pulse_us = pw_current;
    r.target_pulse_us = pw_target;
    return r;
  endfunction

  // Mirrors a register write into the shadow register file.
  function automatic void apply_reg(input logic [CFG_ADDR_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_MIN_PULSE: pw_cfg.min_pulse = val[14:0];
      REG_MAX_PULSE: pw_cfg.max_pulse = val[14:0];
      REG_MIN_ANGLE: pw_cfg.min_angle = val[12:0];
      REG_MAX_ANGLE: pw_cfg.max_angle = val[12:0];
      REG_CENTER:    pw_cfg.center = val[12:0];
      REG_SLEW:      pw_cfg.slew = val[14:0];
      REG_DEADBAND:  pw_cfg.deadband = val[14:0];
      REG_HOLD_MS:   pw_cfg.hold_ms = val[13:0];
      default: ;
    endcase
  endfunction

  // Offsets lean toward the clamp extremes and small values near center.
  function automatic logic [12:0] rand_offset();
    logic [12:0] r;
    case ($urandom_range(0, 9))
      0: r = 13'h1000;
      1: r = 13'h0FFF;
      2: r = 13'd3600;
      3: r = 13'h11F0;
      4: r = 13'h0000;
      5: r = 13'($urandom_range(0, 8)) - 13'd4;
      default: r = 13'($urandom);
    endcase
    return r;
  endfunction

  // Random register value, one of the field extremes a quarter of the time each way.
  function automatic logic [14:0] rand_reg(input int idx);
    logic [14:0] v;
    int          pick;
    pick = $urandom_range(0, 3);
    v = 15'($urandom);
    case (idx)
      REG_MIN_ANGLE, REG_MAX_ANGLE, REG_CENTER: begin
        if (pick == 0) v = {v[14:13], 13'h1000};
        else if (pick == 1) v = {v[14:13], 13'h0FFF};
      end
      REG_SLEW: begin
        if (pick == 0) v = '0;
        else if (pick == 1) v = 15'h7FFF;
        else v = 15'($urandom_range(0, 600));
      end
      REG_DEADBAND: begin
        if (pick == 0) v = '0;
        else if (pick == 1) v = 15'h7FFF;
        else v = 15'($urandom_range(0, 50));
      end
      REG_HOLD_MS: begin
        if (pick == 0) v = '0;
        else if (pick == 1) v = 15'h7FFF;
        else v = 15'($urandom_range(0, 30));
      end
      default: begin
        if (pick == 0) v = '0;
        else if (pick == 1) v = 15'h7FFF;
        else v = 15'($urandom_range(0, 3000));
      end
    endcase
    return v;
  endfunction

  // Register settings of each phase; the first few are fixed corner settings.
  task automatic fill_phase_regs(input int p);
    case (p)
      0: phase_vals = '{15'd500, 15'd2500, 15'd0, 15'd1800, 15'd1000, 15'd15, 15'd6, 15'd250};
      1: phase_vals = '{15'd500, 15'd2500, 15'd0, 15'd1800, 15'd900, 15'd20000, 15'd20000,
                        15'd0};
      2: phase_vals = '{15'd20000, 15'h7FFF, 15'h1000, 15'h0FFF, 15'd0, 15'h7FFF, 15'd0,
                        15'h7FFF};
      3: phase_vals = '{15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0};
      4: phase_vals = '{15'd3000, 15'd1000, 15'd1000, 15'h1C18, 15'd0, 15'd500, 15'd100,
                        15'd5};
      5: phase_vals = '{15'd100, 15'd103, 15'h1FFE, 15'd2, 15'd0, 15'd7, 15'd3, 15'd1};
      default: begin
        for (int i = 0; i < 8; i++) phase_vals[i] = rand_reg(i);
      end
    endcase
  endtask

  // Offers one item, waits for its transaction and records the expected result.
  task automatic send_item(input logic kind, input logic [12:0] offs,
                           input logic typed, input servo_out_t want);
    servo_out_t pred;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, offs};
    do @(posedge clk); while (!in_tready);
    pred = next_servo_output(kind, offs);
    pending_outputs.push_back(typed ? want : pred);
    n_items++;
    if (kind == REQ_CMD) n_cmds++;
  endtask

  // Holds the sender off until every outstanding result has arrived.
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_outputs.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random back-pressure and in-order comparison.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen_out = out_tdata;
        results_seen++;
        if (pending_outputs.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("ERROR: result transaction %0d with nothing expected: %h",
                     results_seen, out_tdata);
        end else begin
          want_out = pending_outputs.pop_front();
          if (seen_out.pwm_level !== want_out.pwm_level ||
              seen_out.output_active !== want_out.output_active ||
              seen_out.current_pulse_us !== want_out.current_pulse_us ||
              seen_out.target_pulse_us !== want_out.target_pulse_us) begin
            bad_results++;
            if (bad_results <= 10) begin
              $display("ERROR: result %0d exp lvl=%0b act=%0b cur=%0d tgt=%0d",
                       results_seen, want_out.pwm_level, want_out.output_active,
                       want_out.current_pulse_us, want_out.target_pulse_us);
              $display("       got lvl=%0b act=%0b cur=%0d tgt=%0d",
                       seen_out.pwm_level, seen_out.output_active,
                       seen_out.current_pulse_us, seen_out.target_pulse_us);
            end
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Main sequence: reset, directed table, then randomized register phases.
  initial begin
    logic kind;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].kind == ROW_REG) begin
        drain_outputs();
        write_reg(DIR_TABLE[i].reg_idx, DIR_TABLE[i].value);
      end else begin
        send_item(DIR_TABLE[i].req, DIR_TABLE[i].value[12:0], DIR_TABLE[i].typed,
                  DIR_TABLE[i].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_outputs();
      fill_phase_regs(p);
      for (int r = 0; r < 8; r++) write_reg(r[CFG_ADDR_W-1:0], phase_vals[r]);
      n_settings++;
      // Phase one runs with no idling on either side.
      idle_pct  = (p == 1) ? 0 : 34;
      stall_pct = (p == 1) ? 0 : 34;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) drain_outputs();
        kind = ($urandom_range(0, 99) < 20) ? REQ_CMD : REQ_TICK;
        send_item(kind, rand_offset(), 1'b0, '0);
      end
    end

    drain_outputs();
    repeat (40) @(posedge clk);
    if (pending_outputs.size() != 0) bad_results++;

    $display("Run covered %0d items (%0d angle commands) over %0d register settings.",
             n_items, n_cmds, n_settings);
    $display("%0d frames completed, output released %0d times, %0d results checked.",
             frames_done, releases, results_seen);
    if (bad_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #40000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
